// File: rtl/core/sipuri_pkg.sv
// sipuri_pkg: types, phase codes and constants for the sip uri parser
// no dependencies
`timescale 1ns / 1ps
package sipuri_pkg;

  localparam int unsigned MaxUriLen = 1024;
  localparam int unsigned PosW      = 11;

  localparam logic [PosW-1:0] NoneMark = PosW'(MaxUriLen);

  typedef enum logic [3:0] {
    PH_SCHEME  = 4'd0,
    PH_TEL     = 4'd1,
    PH_HSTART  = 4'd2,
    PH_HNAME   = 4'd3,
    PH_BRACKET = 4'd4,
    PH_AFTERBR = 4'd5,
    PH_PORT    = 4'd6,
    PH_PARAMS  = 4'd7,
    PH_SEEKQ   = 4'd8,
    PH_HEADERS = 4'd9,
    PH_HERR    = 4'd10,
    PH_DEAD    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD = 2'd1, ST_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SC_SIP = 2'd0, SC_SIPS = 2'd1, SC_TEL = 2'd2, SC_OTHER = 2'd3
  } scheme_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  scheme;
    logic [9:0]  scheme_len;
    logic [10:0] user_start;
    logic [10:0] user_len;
    logic [10:0] host_start;
    logic [10:0] host_len;
    logic [15:0] port;
    logic [10:0] params_start;
    logic [10:0] params_len;
    logic [10:0] headers_start;
    logic [10:0] headers_len;
  } out_item_t;

  // parser state carried from byte to byte
  typedef struct packed {
    logic [PosW-1:0] pos;
    phase_t          phase;
    logic [31:0]     chars;
    logic [PosW-1:0] scheme_end;
    logic [PosW-1:0] last_at;
    logic            tail_seen;
    logic [PosW-1:0] host_begin;
    logic [PosW-1:0] host_finish;
    logic            in_br;
    logic [16:0]     port_acc;
    logic [2:0]      port_cnt;
    logic [PosW-1:0] params_begin;
    logic [PosW-1:0] query_begin;
    logic [1:0]      err;
  } pstate_t;

  function automatic logic is_port_stop(input logic [7:0] c);
    return c == 8'h3B || c == 8'h3F || c == 8'h20 || c == 8'h09;
  endfunction

  function automatic logic is_host_stop(input logic [7:0] c);
    return c == 8'h3A || is_port_stop(c);
  endfunction

  function automatic scheme_t scheme_code(input logic [PosW-1:0] se, input logic [31:0] ch);
    if (se == PosW'(3) && ch == 32'h0073_6970) return SC_SIP;
    if (se == PosW'(4) && ch == 32'h7369_7073) return SC_SIPS;
    if (se == PosW'(3) && ch == 32'h0074_656C) return SC_TEL;
    return SC_OTHER;
  endfunction

  function automatic logic port_ok(input pstate_t s);
    return s.port_cnt != 3'd0 && s.port_acc >= 17'd1 && s.port_acc <= 17'd65535;
  endfunction

  function automatic pstate_t reset_state();
    pstate_t s;
    s = '0;
    s.phase        = PH_SCHEME;
    s.scheme_end   = NoneMark;
    s.last_at      = NoneMark;
    s.host_begin   = NoneMark;
    s.params_begin = NoneMark;
    s.query_begin  = NoneMark;
    return s;
  endfunction

endpackage

// File: rtl/core/sipuri_step.sv
// sipuri_step: combinational next state for one uri byte
// depends on sipuri_pkg
`timescale 1ns / 1ps
module sipuri_step
  import sipuri_pkg::*;
(
  input  pstate_t    cur,
  input  logic [7:0] c,
  output pstate_t    nxt
);

  logic            host_side;
  logic [PosW-1:0] p;
  logic [PosW-1:0] p1;
  logic [7:0]      lc;
  logic [20:0]     acc10;

  always_comb begin
    nxt       = cur;
    p         = cur.pos;
    p1        = cur.pos + PosW'(1);
    host_side = cur.phase >= PH_HSTART && cur.phase <= PH_HERR;
    lc        = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    acc10     = 21'(cur.port_acc) * 21'd10 + 21'(c - 8'h30);
    if (cur.err == 2'd2 || cur.pos >= PosW'(MaxUriLen)) begin
      nxt.err = 2'd2;
    end else begin
      nxt.pos = p1;
      if (host_side && !cur.tail_seen && c == 8'h40) begin
        nxt.last_at      = p;
        nxt.host_begin   = p1;
        nxt.host_finish  = '0;
        nxt.in_br        = 1'b0;
        nxt.port_acc     = '0;
        nxt.port_cnt     = '0;
        nxt.params_begin = NoneMark;
        nxt.query_begin  = NoneMark;
        if (cur.err == 2'd1) nxt.err = 2'd0;
        nxt.phase = PH_HSTART;
      end else begin
        case (cur.phase)
          PH_SCHEME: begin
            if (c == 8'h3A) begin
              if (p == '0) begin
                nxt.err   = 2'd1;
                nxt.phase = PH_DEAD;
              end else begin
                nxt.scheme_end = p;
                if (scheme_code(p, cur.chars) == SC_TEL) begin
                  nxt.phase = PH_TEL;
                end else begin
                  nxt.host_begin   = p1;
                  nxt.host_finish  = '0;
                  nxt.in_br        = 1'b0;
                  nxt.port_acc     = '0;
                  nxt.port_cnt     = '0;
                  nxt.params_begin = NoneMark;
                  nxt.query_begin  = NoneMark;
                  if (cur.err == 2'd1) nxt.err = 2'd0;
                  nxt.phase = PH_HSTART;
                end
              end
            end else if (p < PosW'(4)) begin
              nxt.chars = {cur.chars[23:0], lc};
            end
          end
          PH_TEL: begin
            if (c == 8'h3B || c == 8'h3F) begin
              if (p == cur.scheme_end + PosW'(1)) begin
                nxt.err   = 2'd1;
                nxt.phase = PH_DEAD;
              end else begin
                nxt.host_finish = p;
                if (c == 8'h3B) begin
                  nxt.params_begin = p1;
                  nxt.phase        = PH_PARAMS;
                end else begin
                  nxt.query_begin = p1;
                  nxt.phase       = PH_HEADERS;
                end
              end
            end
          end
          PH_HSTART: begin
            if (c == 8'h5B) begin
              nxt.in_br      = 1'b1;
              nxt.host_begin = p1;
              nxt.phase      = PH_BRACKET;
            end else if (is_host_stop(c)) begin
              nxt.err   = 2'd1;
              nxt.phase = PH_HERR;
            end else begin
              nxt.phase = PH_HNAME;
            end
          end
          PH_HNAME: begin
            if (is_host_stop(c)) begin
              nxt.host_finish = p;
              if (c == 8'h3A) nxt.phase = PH_PORT;
              else if (c == 8'h3B) begin
                nxt.params_begin = p1;
                nxt.phase        = PH_PARAMS;
              end else if (c == 8'h3F) begin
                nxt.query_begin = p1;
                nxt.phase       = PH_HEADERS;
              end else nxt.phase = PH_SEEKQ;
            end
          end
          PH_BRACKET: begin
            if (c == 8'h5D) begin
              if (p == cur.host_begin) begin
                nxt.err   = 2'd1;
                nxt.phase = PH_HERR;
              end else begin
                nxt.host_finish = p;
                nxt.phase       = PH_AFTERBR;
              end
            end
          end
          PH_AFTERBR: begin
            if (c == 8'h3A) nxt.phase = PH_PORT;
            else if (c == 8'h3B) begin
              nxt.params_begin = p1;
              nxt.phase        = PH_PARAMS;
            end else if (c == 8'h3F) begin
              nxt.query_begin = p1;
              nxt.phase       = PH_HEADERS;
            end else nxt.phase = PH_SEEKQ;
          end
          PH_PORT: begin
            if (c >= 8'h30 && c <= 8'h39) begin
              // accumulator saturates just above the legal range
              nxt.port_acc = (acc10 > 21'd65536) ? 17'd65536 : acc10[16:0];
              if (cur.port_cnt < 3'd7) nxt.port_cnt = cur.port_cnt + 3'd1;
            end else if (is_port_stop(c) && port_ok(cur)) begin
              if (c == 8'h3B) begin
                nxt.params_begin = p1;
                nxt.phase        = PH_PARAMS;
              end else if (c == 8'h3F) begin
                nxt.query_begin = p1;
                nxt.phase       = PH_HEADERS;
              end else nxt.phase = PH_SEEKQ;
            end else begin
              nxt.err   = 2'd1;
              nxt.phase = PH_HERR;
            end
          end
          PH_PARAMS, PH_SEEKQ: begin
            if (c == 8'h3F) begin
              nxt.query_begin = p1;
              nxt.phase       = PH_HEADERS;
            end
          end
          default: ;
        endcase
        if (host_side && (c == 8'h3B || c == 8'h3F)) nxt.tail_seen = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/sipuri_finish.sv
// sipuri_finish: builds the result item from the final parser state
// depends on sipuri_pkg
`timescale 1ns / 1ps
module sipuri_finish
  import sipuri_pkg::*;
(
  input  pstate_t   s,
  output out_item_t res
);

  logic [1:0]      st;
  logic [PosW-1:0] e;
  logic [PosW-1:0] hf;
  logic [PosW-1:0] us;
  scheme_t         sc;

  always_comb begin
    e  = s.pos;
    hf = s.host_finish;
    st = 2'd0;
    if (s.err != 2'd0) st = s.err;
    else begin
      case (s.phase)
        PH_SCHEME, PH_HSTART, PH_BRACKET, PH_HERR, PH_DEAD: st = 2'd1;
        PH_TEL: begin
          if (e == s.scheme_end + PosW'(1)) st = 2'd1;
          else hf = e;
        end
        PH_HNAME: hf = e;
        PH_PORT:  st = port_ok(s) ? 2'd0 : 2'd1;
        default:  st = 2'd0;
      endcase
    end
    sc  = scheme_code(s.scheme_end, s.chars);
    us  = s.scheme_end + PosW'(1);
    res = '0;
    res.status        = st;
    res.user_start    = NoneMark;
    res.host_start    = NoneMark;
    res.params_start  = NoneMark;
    res.headers_start = NoneMark;
    if (st == ST_OK) begin
      res.scheme     = sc;
      res.scheme_len = s.scheme_end[9:0];
      if (sc == SC_TEL) begin
        res.user_start = us;
        res.user_len   = hf - us;
      end else begin
        if (s.last_at != NoneMark) begin
          res.user_start = us;
          res.user_len   = s.last_at - us;
        end
        res.host_start = s.host_begin;
        res.host_len   = hf - s.host_begin;
        if (s.phase >= PH_HSTART && s.port_cnt != 3'd0) res.port = s.port_acc[15:0];
      end
      if (s.params_begin != NoneMark) begin
        res.params_start = s.params_begin;
        res.params_len   = ((s.query_begin != NoneMark) ? s.query_begin - PosW'(1) : e)
                           - s.params_begin;
      end
      if (s.query_begin != NoneMark) begin
        res.headers_start = s.query_begin;
        res.headers_len   = e - s.query_begin;
      end
    end
  end

endmodule

// File: rtl/core/sip_uri_parser_unit.sv
// sip_uri_parser_unit: top level of the sip uri slicer
// depends on sipuri_pkg, sipuri_step, sipuri_finish
`timescale 1ns / 1ps
// Takes one URI byte per transfer and gives one result transfer after the
// byte flagged last_byte. A byte updates the parser state register in the
// cycle it is accepted, and the last byte's result is loaded into the output
// register in the same cycle. A new byte is accepted every cycle while the
// output register is empty or being drained; a last byte is held off only
// while an untaken result still sits there.
module sip_uri_parser_unit
  import sipuri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  pstate_t   st_r, st_nxt, step_s;
  out_item_t res_s;
  out_item_t out_r;
  logic      ovld_r;
  logic      in_xfer;
  logic      out_free;

  sipuri_step u_step (.cur(st_r), .c(in_data.data_byte), .nxt(step_s));
  sipuri_finish u_finish (.s(step_s), .res(res_s));

  assign out_free = !ovld_r || !out_stall;
  assign in_stall = in_data.last_byte && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    st_nxt = st_r;
    if (in_xfer) st_nxt = in_data.last_byte ? reset_state() : step_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= reset_state();
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_xfer && in_data.last_byte) ovld_r <= 1'b1;
      else if (!out_stall) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.last_byte) out_r <= res_s;
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/sipuri_checker.sv
// sipuri_checker: port-level checks on the parser, bound to the top level
// depends on sipuri_pkg
`timescale 1ns / 1ps
module sipuri_checker
  import sipuri_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a result appears only after a last byte transfer
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.last_byte))
    else $error("result without last byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_stall_mid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_data.last_byte |-> !in_stall)
    else $error("middle byte stalled");

  a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != 2'd0 |->
      out_data.port == 16'd0 && out_data.host_start == NoneMark)
    else $error("error result not blanked");

endmodule

bind sip_uri_parser_unit sipuri_checker u_chk (.*);
